FILE: rtl/ipc_pkg.sv
package ipc_pkg;

	// Capacity of the cell chain and element width
	localparam int MAX_ELEMENTS = 1024;
	localparam int VALUE_BITS = 20;

	// Width of the reported count and its modulus
	localparam int COUNT_BITS = 30;
	localparam logic [COUNT_BITS:0] MODULUS = (COUNT_BITS + 1)'(1000000007);

	// Per-request partial count never exceeds MAX_ELEMENTS - 1
	localparam int CNT_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
	// Accepted element count reaches MAX_ELEMENTS itself
	localparam int ELEM_W = $clog2(MAX_ELEMENTS + 1);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
	} in_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] pair_count;
		logic                  overflow;
	} out_t;

	// Request as it travels down the chain
	typedef struct packed {
		logic                  valid;
		logic                  live;    // compare and store; clear for dropped requests
		logic                  last;
		logic                  placed;  // already stored in some cell
		logic                  ovf;
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      count;   // stored values greater than this one so far
	} token_t;

endpackage

FILE: rtl/ipc_cell.sv
module ipc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  ipc_pkg::token_t   tok_in,
	output ipc_pkg::token_t   tok_out
);

	logic                           held_q;
	logic [ipc_pkg::VALUE_BITS-1:0] held_value_q;
	logic                           tok_valid_q;
	ipc_pkg::token_t                tok_data_q;
	ipc_pkg::token_t                tok_next;
	logic                           hit;
	logic                           place;
	logic                           wipe;

	// Compare against the held element, claim an empty cell, wipe on last
	always_comb begin
		hit   = tok_in.valid & tok_in.live & held_q & (held_value_q > tok_in.value);
		place = tok_in.valid & tok_in.live & ~tok_in.last & ~tok_in.placed & ~held_q;
		wipe  = tok_in.valid & tok_in.last;
		tok_next        = tok_in;
		tok_next.count  = tok_in.count + ipc_pkg::CNT_W'(hit);
		tok_next.placed = tok_in.placed | place;
	end

	// Hold the cell's occupancy and the request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			tok_valid_q <= 1'b0;
		end else if (advance) begin
			tok_valid_q <= tok_in.valid;
			if (place) begin
				held_q <= 1'b1;
			end else if (wipe) begin
				held_q <= 1'b0;
			end
		end
	end

	// Store the element and pass the request on
	always_ff @(posedge clk) begin
		if (advance) begin
			tok_data_q <= tok_next;
			if (place) begin
				held_value_q <= tok_in.value;
			end
		end
	end

	always_comb begin
		tok_out       = tok_data_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

FILE: rtl/ipc_tail.sv
module ipc_tail (
	input  logic            clk,
	input  logic            arst_n,
	input  ipc_pkg::token_t tok_in,
	output logic            advance,
	output logic            result_valid,
	input  logic            result_ready,
	output ipc_pkg::out_t   result
);

	logic [ipc_pkg::COUNT_BITS-1:0] run_q;
	logic                           result_valid_q;
	ipc_pkg::out_t                  result_q;
	logic [ipc_pkg::COUNT_BITS:0]   sum;
	logic [ipc_pkg::COUNT_BITS:0]   sum_red;
	logic [ipc_pkg::COUNT_BITS-1:0] total;
	logic                           take;

	// Stall the chain only when a last request meets a result still waiting
	assign advance = ~(tok_in.valid & tok_in.last & result_valid_q & ~result_ready);
	assign take    = tok_in.valid & advance;

	// Add the partial count and reduce once
	always_comb begin
		sum     = {1'b0, run_q} + (ipc_pkg::COUNT_BITS + 1)'(tok_in.count);
		sum_red = (sum >= ipc_pkg::MODULUS) ? (sum - ipc_pkg::MODULUS) : sum;
		total   = sum_red[ipc_pkg::COUNT_BITS-1:0];
	end

	// Advance the running count; emit and restart on last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (take) begin
				if (tok_in.last) begin
					run_q          <= '0;
					result_valid_q <= 1'b1;
				end else begin
					run_q <= total;
				end
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (take && tok_in.last) begin
			result_q.pair_count <= total;
			result_q.overflow   <= tok_in.ovf;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: rtl/inversion_pair_counter_top.sv
// Inversion counter built as a chain of MAX_ELEMENTS compare-and-store cells.
// Throughput: one request per cycle; the chain stalls only while a final request
// reaches the tail and the previous result has not yet been taken.
// A final request passes through the register of every cell and then the accumulator's
// result register before its result is shown.
// Reset: clears all cell occupancy bits, counters and flags at once; no clearing pass.
module inversion_pair_counter_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  ipc_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_ready,
	output ipc_pkg::out_t result
);

	ipc_pkg::token_t            chain [ipc_pkg::MAX_ELEMENTS+1];
	logic                       advance;
	logic                       accept;
	logic                       live;
	logic [ipc_pkg::ELEM_W-1:0] elem_q;
	logic                       drop_q;

	assign item_ready = advance;
	assign accept     = item_valid & advance;
	assign live       = elem_q < ipc_pkg::ELEM_W'(ipc_pkg::MAX_ELEMENTS);

	// Track fill level and drops of the current sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (item.last) begin
				elem_q <= '0;
				drop_q <= 1'b0;
			end else if (live) begin
				elem_q <= elem_q + ipc_pkg::ELEM_W'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// Launch the request into the head of the chain
	always_comb begin
		chain[0].valid  = accept;
		chain[0].live   = live;
		chain[0].last   = item.last;
		chain[0].placed = 1'b0;
		chain[0].ovf    = drop_q | ~live;
		chain[0].value  = item.value;
		chain[0].count  = '0;
	end

	for (genvar i = 0; i < ipc_pkg::MAX_ELEMENTS; i++) begin : g_cell
		ipc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	ipc_tail u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_in       (chain[ipc_pkg::MAX_ELEMENTS]),
		.advance      (advance),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
